>>> src/msbx_pkg.sv
package msbx_pkg;

  localparam int DEF_STORE_BYTES = 1024;

  // prefetch window: bit offset up to 7 plus 32 bits spans five bytes
  localparam int WIN_BYTES = 5;
  localparam int WIN_BITS  = WIN_BYTES * 8;
  localparam int WIN_CW    = $clog2(WIN_BYTES + 1);

  localparam int MAX_BITS = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_ALIGN = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

>>> src/msb_first_bit_extractor_unit.sv
// result: a request's result is registered as it is accepted and is valid in the cycle after
// throughput: one request per cycle while the output is not stalled and the prefetch window
// holds the bits a read needs; the window refills one byte per cycle from the ring's single read
// port, with a gap after each read, so back-to-back 32-bit reads stall on the refill
// reset: clears ring pointers, byte count, bit offset, window byte count, fetch in flight and
// output valid; window and ring contents stay undefined until filled
module msb_first_bit_extractor_unit
  import msbx_pkg::*;
#(
  parameter int STORE_BYTES = DEF_STORE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  bit_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic [1:0]  status
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = $clog2(STORE_BYTES + 1);

  logic [AW-1:0]       write_index, write_index_next;
  logic [AW-1:0]       fetch_index, fetch_index_next;
  logic [CW-1:0]       bytes_held, bytes_held_next;
  logic [2:0]          bit_offset, bit_offset_next;
  logic [WIN_BITS-1:0] win, win_next;
  logic [WIN_CW-1:0]   win_cnt, win_cnt_next;
  logic                pend;
  logic                issue;
  logic [7:0]          rdata;

  logic                accept;
  logic                push_ok;
  logic [CW+2:0]       avail;
  logic [5:0]          n_sat;
  logic [5:0]          total;
  logic                read_ok;
  logic                read_wait;
  logic [2:0]          consumed;
  logic [WIN_CW-1:0]   ahead;
  logic [WIN_BITS-1:0] win_off;
  logic [WIN_BITS-1:0] win_sh;
  logic [WIN_CW-1:0]   cnt_after;
  logic [31:0]         value_next;
  status_t             status_next;
  op_t                 op;

  msbx_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_ring (
    .clk  (clk),
    .we   (push_ok),
    .waddr(write_index),
    .wdata(data_byte),
    .raddr(fetch_index),
    .rdata(rdata)
  );

  always_comb begin
    op        = op_t'(opcode);
    n_sat     = (bit_count > 6'(MAX_BITS)) ? 6'(MAX_BITS) : bit_count;
    avail     = {bytes_held, 3'b000} - (CW+3)'(bit_offset);
    total     = 6'(bit_offset) + n_sat;
    read_ok   = ((CW+3)'(n_sat) <= avail);
    // enough bits buffered but not yet pulled into the window
    read_wait = (op == OP_READ) && read_ok &&
                ((WIN_CW+3)'({win_cnt, 3'b000}) < (WIN_CW+3)'(total));
    in_ready  = (!out_valid || out_ready) && !read_wait;
    accept    = in_valid && in_ready;

    push_ok     = 1'b0;
    consumed    = 3'd0;
    bit_offset_next = bit_offset;
    value_next  = '0;
    status_next = ST_OK;
    win_off     = win << bit_offset;

    if (accept) begin
      case (op)
        OP_PUSH: begin
          if (bytes_held == CW'(STORE_BYTES)) begin
            status_next = ST_FULL;
          end else begin
            push_ok = 1'b1;
          end
        end
        OP_READ: begin
          if (!read_ok) begin
            status_next = ST_SHORT;
          end else begin
            value_next      = win_off[WIN_BITS-1 -: 32] >> (6'(MAX_BITS) - n_sat);
            consumed        = total[5:3];
            bit_offset_next = total[2:0];
          end
        end
        OP_ALIGN: begin
          if (bit_offset != 3'd0) begin
            consumed = 3'd1;
          end
          bit_offset_next = 3'd0;
        end
        default: begin
        end
      endcase
    end

    bytes_held_next  = bytes_held + CW'(push_ok) - CW'(consumed);
    write_index_next = write_index;
    if (push_ok) begin
      write_index_next = (write_index == AW'(STORE_BYTES - 1)) ? '0 : write_index + AW'(1);
    end

    // prefetch the next held byte beyond the window and the read in flight
    ahead = win_cnt + WIN_CW'(pend);
    issue = (ahead < WIN_CW'(WIN_BYTES)) && (CW'(ahead) < bytes_held);
    fetch_index_next = fetch_index;
    if (issue) begin
      fetch_index_next = (fetch_index == AW'(STORE_BYTES - 1)) ? '0 : fetch_index + AW'(1);
    end

    // drop consumed bytes, then append the returning byte behind the rest
    win_sh    = win << {consumed, 3'b000};
    cnt_after = win_cnt - WIN_CW'(consumed);
    win_next  = win_sh;
    if (pend) begin
      for (int k = 0; k < WIN_BYTES; k++) begin
        if (cnt_after == WIN_CW'(k)) begin
          win_next[WIN_BITS-1-8*k -: 8] = rdata;
        end
      end
    end
    win_cnt_next = cnt_after + WIN_CW'(pend);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      fetch_index <= '0;
      bytes_held  <= '0;
      bit_offset  <= '0;
      win_cnt     <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      write_index <= write_index_next;
      fetch_index <= fetch_index_next;
      bytes_held  <= bytes_held_next;
      bit_offset  <= bit_offset_next;
      win_cnt     <= win_cnt_next;
      pend        <= issue;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
    if (accept) begin
      value  <= value_next;
      status <= status_next;
    end
  end

endmodule

>>> src/msbx_ram.sv
module msbx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/sv/msbx_stream_checker.sv
`timescale 1ns / 100ps

module msbx_stream_checker
  import msbx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  bit_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] value,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          owed_count
);

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } extract_t;

  logic [7:0]  ring [DEF_STORE_BYTES];
  int unsigned rd_ptr;
  int unsigned wr_ptr;
  int unsigned held;
  int unsigned bit_ofs;
  extract_t    owed_results[$];

  function automatic extract_t apply_request(logic [1:0] op, logic [7:0] data,
                                             logic [5:0] cnt);
    extract_t    res;
    int unsigned n;
    int unsigned pos;
    int unsigned total;
    res.value  = '0;
    res.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (held >= DEF_STORE_BYTES) begin
          res.status = ST_FULL;
        end else begin
          ring[wr_ptr] = data;
          wr_ptr = (wr_ptr + 1) % DEF_STORE_BYTES;
          held++;
        end
      end
      OP_READ: begin
        n = (cnt > MAX_BITS) ? MAX_BITS : cnt;
        if (n > held * 8 - bit_ofs) begin
          res.status = ST_SHORT;
        end else if (n > 0) begin
          for (int i = 0; i < n; i++) begin
            pos = bit_ofs + i;
            res.value = {res.value[30:0], ring[(rd_ptr + pos / 8) % DEF_STORE_BYTES][7 - pos % 8]};
          end
          total   = bit_ofs + n;
          rd_ptr  = (rd_ptr + total / 8) % DEF_STORE_BYTES;
          held    = held - total / 8;
          bit_ofs = total % 8;
        end
      end
      OP_ALIGN: begin
        // a partly used byte is dropped whole
        if (bit_ofs != 0 && held > 0) begin
          rd_ptr = (rd_ptr + 1) % DEF_STORE_BYTES;
          held--;
        end
        bit_ofs = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    extract_t want;
    if (rst) begin
      rd_ptr  = 0;
      wr_ptr  = 0;
      held    = 0;
      bit_ofs = 0;
      owed_results.delete();
    end else begin
      if (in_valid && in_ready)
        owed_results.push_back(apply_request(opcode, data_byte, bit_count));
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t unexpected result: value %h status %0d", $time, value, status);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (value !== want.value) begin
            $display("%0t value mismatch: expected %h actual %h", $time, want.value, value);
            fail_count++;
          end
          if (status !== want.status) begin
            $display("%0t status mismatch: expected %0d actual %0d", $time, want.status,
                     status);
            fail_count++;
          end
        end
      end
    end
    owed_count = owed_results.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import msbx_pkg::*;

  // opcode with no operation behind it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode    = OP_PUSH;
  logic [7:0]  data_byte = '0;
  logic [5:0]  bit_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value;
  logic [1:0]  status;
  int          fail_count;
  int          owed_count;
  bit          no_idle   = 1'b0;

  msb_first_bit_extractor_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .data_byte (data_byte),
    .bit_count (bit_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
  );

  msbx_stream_checker stream_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .data_byte  (data_byte),
    .bit_count  (bit_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .status     (status),
    .fail_count (fail_count),
    .owed_count (owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_request(input logic [1:0] op, input logic [7:0] data,
                              input logic [5:0] cnt);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= data;
    bit_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(input int unsigned push_w, input int unsigned read_w,
                             input int unsigned align_w);
    int unsigned roll;
    logic [1:0]  op;
    logic [5:0]  cnt;
    roll = $urandom_range(0, 99);
    if (roll < push_w)
      op = OP_PUSH;
    else if (roll < push_w + read_w)
      op = OP_READ;
    else if (roll < push_w + read_w + align_w)
      op = OP_ALIGN;
    else
      op = OP_UNUSED;
    // mostly legal sizes, now and then an oversized count
    if ($urandom_range(0, 9) == 0)
      cnt = 6'($urandom_range(33, 63));
    else
      cnt = 6'($urandom_range(0, 32));
    send_request(op, 8'($urandom_range(0, 255)), cnt);
  endtask

  initial begin : sink
    int unsigned stall;
    wait (!rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // requests on an empty store, then push five bytes
    send_request(OP_READ, 8'h00, 6'd0);
    send_request(OP_READ, 8'h00, 6'd1);
    send_request(OP_ALIGN, 8'h00, 6'd0);
    send_request(OP_UNUSED, 8'h00, 6'd0);
    send_request(OP_PUSH, 8'hFF, 6'd0);
    send_request(OP_PUSH, 8'h00, 6'd0);
    send_request(OP_PUSH, 8'hA5, 6'd0);
    send_request(OP_PUSH, 8'h5A, 6'd0);
    send_request(OP_PUSH, 8'h80, 6'd0);
    // align off a partial byte, then on a boundary
    send_request(OP_READ, 8'h00, 6'd1);
    send_request(OP_ALIGN, 8'h00, 6'd0);
    send_request(OP_ALIGN, 8'h00, 6'd0);
    send_request(OP_READ, 8'h00, 6'd0);
    send_request(OP_PUSH, 8'h01, 6'd0);
    send_request(OP_PUSH, 8'hC3, 6'd0);
    // unaligned full-width read across five bytes, oversized count
    send_request(OP_READ, 8'h00, 6'd3);
    send_request(OP_READ, 8'h00, 6'd63);
    send_request(OP_READ, 8'h00, 6'd40);
    send_request(OP_READ, 8'h00, 6'd13);
    send_request(OP_READ, 8'h00, 6'd1);
    send_request(OP_UNUSED, 8'hFF, 6'd63);
    send_request(OP_PUSH, 8'h3C, 6'd0);
    send_request(OP_READ, 8'h00, 6'd32);

    repeat (30) send_random(50, 35, 10);
    // fill past capacity so the tail of the burst is refused, wrapping the write side
    repeat (1030) send_random(100, 0, 0);
    // drain part of the full store
    repeat (40) send_random(15, 75, 7);
    no_idle = 1'b1;
    repeat (30) send_random(45, 40, 10);
    no_idle = 1'b0;
    repeat (20) send_random(40, 45, 10);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (owed_count == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
